/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

/* rtl/core/mibd_pkg.sv */
`timescale 1ns / 1ps

package mibd_pkg;

	// Record forms
	localparam logic [2:0] FORM_REGMEM  = 3'd0;
	localparam logic [2:0] FORM_IMM_MEM = 3'd1;
	localparam logic [2:0] FORM_IMM_REG = 3'd2;
	localparam logic [2:0] FORM_MEM_ACC = 3'd3;
	localparam logic [2:0] FORM_ACC_MEM = 3'd4;
	localparam logic [2:0] FORM_UNSUP   = 3'd5;

	// Opcode patterns and the masks that select their fixed bits
	localparam logic [7:0] OPC_MOV_RM      = 8'h88;
	localparam logic [7:0] OPC_MOV_IMM_RM  = 8'hC6;
	localparam logic [7:0] OPC_MOV_IMM_REG = 8'hB0;
	localparam logic [7:0] OPC_MOV_MEM_ACC = 8'hA0;
	localparam logic [7:0] OPC_MOV_ACC_MEM = 8'hA2;
	localparam logic [7:0] MASK_DW         = 8'hFC;
	localparam logic [7:0] MASK_W          = 8'hFE;
	localparam logic [7:0] MASK_WREG       = 8'hF0;

	// mod field codes
	localparam logic [1:0] MOD_NONE   = 2'b00;
	localparam logic [1:0] MOD_DISP8  = 2'b01;
	localparam logic [1:0] MOD_DISP16 = 2'b10;

	localparam logic [2:0] RM_DIRECT = 3'b110;

	typedef struct packed {
		logic [2:0]  phase;
		logic [7:0]  opcode;
		logic [7:0]  modrm;
		logic [15:0] disp;
		logic [15:0] data;
	} dec_state_t;

	typedef struct packed {
		logic [2:0]         form;
		logic               direction;
		logic               wide;
		logic [1:0]         mode;
		logic [2:0]         reg_code;
		logic [2:0]         rm_code;
		logic               direct_address;
		logic signed [15:0] displacement;
		logic [15:0]        data_value;
		logic [2:0]         length;
	} dec_result_t;

	function automatic logic [2:0] form_of(input logic [7:0] op);
		if ((op & MASK_DW) == OPC_MOV_RM) return FORM_REGMEM;
		if ((op & MASK_W) == OPC_MOV_IMM_RM) return FORM_IMM_MEM;
		if ((op & MASK_WREG) == OPC_MOV_IMM_REG) return FORM_IMM_REG;
		if ((op & MASK_W) == OPC_MOV_MEM_ACC) return FORM_MEM_ACC;
		if ((op & MASK_W) == OPC_MOV_ACC_MEM) return FORM_ACC_MEM;
		return FORM_UNSUP;
	endfunction

	// Displacement bytes that follow the modrm byte
	function automatic logic [1:0] disp_bytes(input logic [7:0] modrm);
		logic [1:0] n;
		unique case (modrm[7:6])
			MOD_DISP8:  n = 2'd1;
			MOD_DISP16: n = 2'd2;
			MOD_NONE:   n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
			default:    n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

/* rtl/core/mov_instruction_byte_decoder.sv */
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | instr_byte
// out     | out | out_valid/out_stall| form .. length (one record per MOV or unsupported byte)
//
// Takes one byte per cycle while in_stall is low; each byte passes an input
// register, then the phase logic in mibd_step, then the result register, which
// takes a finished record only while it is empty or not stalled.
// arst_n clears the phase machine, held fields and both valid flags.
// in_stall rises only when a byte that finishes a record waits on a full,
// stalled result register; bytes that finish nothing keep flowing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mov_instruction_byte_decoder import mibd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         instr_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         form,
	output logic               direction,
	output logic               wide,
	output logic [1:0]         mode,
	output logic [2:0]         reg_code,
	output logic [2:0]         rm_code,
	output logic               direct_address,
	output logic signed [15:0] displacement,
	output logic [15:0]        data_value,
	output logic [2:0]         length
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	logic        step_valid;
	dec_result_t step_res;
	logic        valid_s2;
	dec_result_t res_s2;
	logic        out_free;
	logic        advance;

	mibd_step u_step (
		.cur       (state_q),
		.byte_in   (byte_s1),
		.nxt       (state_nxt),
		.res_valid (step_valid),
		.res       (step_res)
	);

	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && (!step_valid || out_free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= instr_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && step_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_valid) begin
			res_s2 <= step_res;
		end
	end

	assign out_valid      = valid_s2;
	assign form           = res_s2.form;
	assign direction      = res_s2.direction;
	assign wide           = res_s2.wide;
	assign mode           = res_s2.mode;
	assign reg_code       = res_s2.reg_code;
	assign rm_code        = res_s2.rm_code;
	assign direct_address = res_s2.direct_address;
	assign displacement   = res_s2.displacement;
	assign data_value     = res_s2.data_value;
	assign length         = res_s2.length;

	`ASSERT_NEVER(a_phase_range, clk, arst_n, state_q.phase == 3'd6 || state_q.phase == 3'd7)
	`ASSERT_NEVER(a_held_opcode_known, clk, arst_n, state_q.phase != 3'd0 && form_of(state_q.opcode) == FORM_UNSUP)
	`ASSERT_CLK(a_done_rewinds, clk, arst_n, advance && step_valid |=> state_q.phase == 3'd0)
	`ASSERT_CLK(a_unsup_one_byte, clk, arst_n, out_valid && form == FORM_UNSUP |-> length == 3'd1)

endmodule

/* rtl/core/mibd_step.sv */
`timescale 1ns / 1ps

module mibd_step import mibd_pkg::*; (
	input  dec_state_t  cur,
	input  logic [7:0]  byte_in,
	output dec_state_t  nxt,
	output logic        res_valid,
	output dec_result_t res
);

	logic [2:0] frm;
	logic [1:0] dn_cur;
	logic [1:0] dn_new;
	logic [2:0] total;
	logic [2:0] rel;
	logic [1:0] mod_f;
	logic [2:0] rm_f;
	logic [7:0] modrm_new;

	assign frm       = form_of(cur.opcode);
	assign dn_cur    = disp_bytes(cur.modrm);
	assign rel       = cur.phase - 3'd2;
	// modrm as it stands after this byte; only the modrm forms use it
	assign modrm_new = (cur.phase == 3'd1) ? byte_in : cur.modrm;
	assign dn_new    = disp_bytes(modrm_new);
	assign mod_f     = modrm_new[7:6];
	assign rm_f      = modrm_new[2:0];

	always_comb begin
		unique case (frm)
			FORM_REGMEM:  total = 3'd2 + {1'b0, dn_new};
			FORM_IMM_MEM: total = 3'd3 + {1'b0, dn_new} + {2'b00, cur.opcode[0]};
			FORM_IMM_REG: total = 3'd2 + {2'b00, cur.opcode[3]};
			default:      total = 3'd3;
		endcase
	end

	always_comb begin
		nxt       = cur;
		res_valid = 1'b0;
		res       = '0;
		if (cur.phase == 3'd0) begin
			nxt.opcode = byte_in;
			nxt.modrm  = '0;
			nxt.disp   = '0;
			nxt.data   = '0;
			if (form_of(byte_in) == FORM_UNSUP) begin
				res_valid  = 1'b1;
				res.form   = FORM_UNSUP;
				res.length = 3'd1;
			end else begin
				nxt.phase = 3'd1;
			end
		end else begin
			if (frm == FORM_REGMEM || frm == FORM_IMM_MEM) begin
				if (cur.phase == 3'd1) begin
					nxt.modrm = byte_in;
				end else if (rel < {1'b0, dn_cur}) begin
					// odd phase carries the displacement high byte
					if (cur.phase[0]) nxt.disp = cur.disp | {byte_in, 8'h00};
					else nxt.disp = cur.disp | {8'h00, byte_in};
				end else begin
					if (cur.phase[0] ^ dn_cur[0]) nxt.data = cur.data | {byte_in, 8'h00};
					else nxt.data = cur.data | {8'h00, byte_in};
				end
			end else begin
				if (!cur.phase[0]) nxt.data = cur.data | {byte_in, 8'h00};
				else nxt.data = cur.data | {8'h00, byte_in};
			end
			nxt.phase = cur.phase + 3'd1;

			if (nxt.phase >= total) begin
				nxt.phase  = 3'd0;
				res_valid  = 1'b1;
				res.form   = frm;
				res.length = total;
				if (frm == FORM_REGMEM || frm == FORM_IMM_MEM) begin
					res.direction      = (frm == FORM_REGMEM) ? cur.opcode[1] : 1'b0;
					res.wide           = cur.opcode[0];
					res.mode           = mod_f;
					res.reg_code       = (frm == FORM_REGMEM) ? nxt.modrm[5:3] : 3'd0;
					res.rm_code        = rm_f;
					res.direct_address = (mod_f == MOD_NONE) && (rm_f == RM_DIRECT);
					// sign-extend the short displacement
					if (mod_f == MOD_DISP8) res.displacement = {{8{nxt.disp[7]}}, nxt.disp[7:0]};
					else res.displacement = nxt.disp;
					res.data_value     = (frm == FORM_IMM_MEM) ? nxt.data : 16'd0;
				end else if (frm == FORM_IMM_REG) begin
					res.direction  = 1'b1;
					res.wide       = cur.opcode[3];
					res.reg_code   = cur.opcode[2:0];
					res.data_value = nxt.data;
				end else begin
					res.direction  = (frm == FORM_MEM_ACC);
					res.wide       = cur.opcode[0];
					res.data_value = nxt.data;
				end
			end
		end
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import mibd_pkg::*;

	localparam logic [1:0] MOD_REG = 2'b11;
	localparam int LATENCY = 4;

	class mov_scoreboard;
		logic [2:0]  phase;
		logic [7:0]  opc_q;
		logic [7:0]  modrm_q;
		logic [15:0] disp_acc;
		logic [15:0] data_acc;
		dec_result_t pending[$];
		int unsigned errors;

		function new();
			phase = '0;
			opc_q = '0;
			modrm_q = '0;
			disp_acc = '0;
			data_acc = '0;
			errors = 0;
		endfunction

		function logic [2:0] form_for(logic [7:0] op);
			if ((op & MASK_DW) == OPC_MOV_RM) return FORM_REGMEM;
			if ((op & MASK_W) == OPC_MOV_IMM_RM) return FORM_IMM_MEM;
			if ((op & MASK_WREG) == OPC_MOV_IMM_REG) return FORM_IMM_REG;
			if ((op & MASK_W) == OPC_MOV_MEM_ACC) return FORM_MEM_ACC;
			if ((op & MASK_W) == OPC_MOV_ACC_MEM) return FORM_ACC_MEM;
			return FORM_UNSUP;
		endfunction

		function int disp_len(logic [7:0] m);
			if (m[7:6] == MOD_DISP8) return 1;
			if (m[7:6] == MOD_DISP16) return 2;
			if (m[7:6] == MOD_NONE && m[2:0] == RM_DIRECT) return 2;
			return 0;
		endfunction

		// Advance the decoder by one byte; queue the record it completes, if any.
		function void note_byte(logic [7:0] b);
			dec_result_t r;
			logic [2:0] f;
			int pos;
			int dn;
			int total;
			r = '0;
			if (phase == 3'd0) begin
				opc_q = b;
				modrm_q = '0;
				disp_acc = '0;
				data_acc = '0;
				if (form_for(b) == FORM_UNSUP) begin
					r.form = FORM_UNSUP;
					r.length = 3'd1;
					pending.push_back(r);
				end else begin
					phase = 3'd1;
				end
				return;
			end
			f = form_for(opc_q);
			pos = int'(phase);
			dn = disp_len(modrm_q);
			if (f == FORM_REGMEM || f == FORM_IMM_MEM) begin
				if (pos == 1) begin
					modrm_q = b;
					dn = disp_len(modrm_q);
				end else if (pos - 2 < dn) begin
					disp_acc |= 16'(b) << (8 * ((pos - 2) & 1));
				end else begin
					data_acc |= 16'(b) << (8 * ((pos - 2 - dn) & 1));
				end
			end else begin
				data_acc |= 16'(b) << (8 * ((pos - 1) & 1));
			end
			phase = phase + 3'd1;
			case (f)
				FORM_REGMEM:  total = 2 + dn;
				FORM_IMM_MEM: total = 3 + dn + int'(opc_q[0]);
				FORM_IMM_REG: total = 2 + int'(opc_q[3]);
				default:      total = 3;
			endcase
			if (int'(phase) < total) return;
			phase = 3'd0;
			r.form = f;
			r.length = 3'(total);
			if (f == FORM_REGMEM || f == FORM_IMM_MEM) begin
				r.direction = (f == FORM_REGMEM) ? opc_q[1] : 1'b0;
				r.wide = opc_q[0];
				r.mode = modrm_q[7:6];
				r.reg_code = (f == FORM_REGMEM) ? modrm_q[5:3] : 3'd0;
				r.rm_code = modrm_q[2:0];
				r.direct_address = (modrm_q[7:6] == MOD_NONE && modrm_q[2:0] == RM_DIRECT);
				r.displacement = disp_acc;
				if (modrm_q[7:6] == MOD_DISP8)
					r.displacement = {{8{disp_acc[7]}}, disp_acc[7:0]};
				r.data_value = (f == FORM_IMM_MEM) ? data_acc : 16'd0;
			end else if (f == FORM_IMM_REG) begin
				r.direction = 1'b1;
				r.wide = opc_q[3];
				r.reg_code = opc_q[2:0];
				r.data_value = data_acc;
			end else begin
				r.direction = (f == FORM_MEM_ACC);
				r.wide = opc_q[0];
				r.data_value = data_acc;
			end
			pending.push_back(r);
		endfunction

		function void cmp(string name, logic [15:0] want, logic [15:0] seen);
			if (want !== seen) begin
				$display("%0t %s mismatch: expected %0h, actual %0h",
					$time, name, want, seen);
				errors++;
			end
		endfunction

		function void check_record(dec_result_t got);
			dec_result_t want;
			if (pending.size() == 0) begin
				$display("%0t unexpected record: expected none, actual form %0d",
					$time, got.form);
				errors++;
				return;
			end
			want = pending.pop_front();
			cmp("form", 16'(want.form), 16'(got.form));
			cmp("direction", 16'(want.direction), 16'(got.direction));
			cmp("wide", 16'(want.wide), 16'(got.wide));
			cmp("mode", 16'(want.mode), 16'(got.mode));
			cmp("reg_code", 16'(want.reg_code), 16'(got.reg_code));
			cmp("rm_code", 16'(want.rm_code), 16'(got.rm_code));
			cmp("direct_address", 16'(want.direct_address), 16'(got.direct_address));
			cmp("displacement", 16'(want.displacement), 16'(got.displacement));
			cmp("data_value", want.data_value, got.data_value);
			cmp("length", 16'(want.length), 16'(got.length));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         instr_byte;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         form;
	logic               direction;
	logic               wide;
	logic [1:0]         mode;
	logic [2:0]         reg_code;
	logic [2:0]         rm_code;
	logic               direct_address;
	logic signed [15:0] displacement;
	logic [15:0]        data_value;
	logic [2:0]         length;

	mov_scoreboard sb = new();
	int unsigned bytes_sent = 0;
	bit send_calm = 0;
	bit recv_calm = 0;
	bit hold_results_req = 0;

	mov_instruction_byte_decoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.instr_byte(instr_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.form(form),
		.direction(direction),
		.wide(wide),
		.mode(mode),
		.reg_code(reg_code),
		.rm_code(rm_code),
		.direct_address(direct_address),
		.displacement(displacement),
		.data_value(data_value),
		.length(length)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Offer one request after a random gap (none when send_calm is set) and hold it until accepted.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		instr_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Send a complete instruction; operand bytes follow from the opcode and modrm.
	task automatic emit_mov(input logic [7:0] opc, input logic [7:0] modrm,
			input logic [15:0] disp, input logic [15:0] imm);
		logic [2:0] f;
		int dn;
		f = sb.form_for(opc);
		dn = sb.disp_len(modrm);
		send_byte(opc);
		case (f)
			FORM_REGMEM, FORM_IMM_MEM: begin
				send_byte(modrm);
				if (dn > 0) send_byte(disp[7:0]);
				if (dn > 1) send_byte(disp[15:8]);
				if (f == FORM_IMM_MEM) begin
					send_byte(imm[7:0]);
					if (opc[0]) send_byte(imm[15:8]);
				end
			end
			FORM_IMM_REG: begin
				send_byte(imm[7:0]);
				if (opc[3]) send_byte(imm[15:8]);
			end
			FORM_MEM_ACC, FORM_ACC_MEM: begin
				send_byte(imm[7:0]);
				send_byte(imm[15:8]);
			end
			default: ;
		endcase
	endtask

	task automatic random_instr();
		logic [7:0] rb;
		logic [7:0] modrm;
		logic [7:0] opc;
		rb = 8'($urandom);
		modrm = 8'($urandom);
		if ($urandom_range(0, 7) == 0) modrm = {MOD_NONE, modrm[5:3], RM_DIRECT};
		case ($urandom_range(0, 9))
			0, 1: opc = OPC_MOV_RM | (rb & ~MASK_DW);
			2, 3: opc = OPC_MOV_IMM_RM | (rb & ~MASK_W);
			4, 5: opc = OPC_MOV_IMM_REG | (rb & ~MASK_WREG);
			6:    opc = OPC_MOV_MEM_ACC | (rb & ~MASK_W);
			7:    opc = OPC_MOV_ACC_MEM | (rb & ~MASK_W);
			default: opc = rb;
		endcase
		// Noise: a lone byte, possibly an opcode whose operands never come.
		if ($urandom_range(0, 99) < 12)
			send_byte(rb);
		else
			emit_mov(opc, modrm, 16'($urandom), 16'($urandom));
	endtask

	// Hold the input until every record predicted so far has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	initial begin
		int unsigned target;
		arst_n = 1'b0;
		in_valid = 1'b0;
		instr_byte = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		emit_mov(8'h00, 8'h00, 16'h0000, 16'h0000);
		emit_mov(8'hFF, 8'h00, 16'h0000, 16'h0000);
		emit_mov(OPC_MOV_RM, {MOD_NONE, 3'd0, RM_DIRECT}, 16'h8000, 16'h0);
		emit_mov(OPC_MOV_RM | 8'h3, {MOD_DISP8, 3'd7, 3'd5}, 16'h0080, 16'h0);
		emit_mov(OPC_MOV_RM | 8'h1, {MOD_DISP8, 3'd2, 3'd1}, 16'h007F, 16'h0);
		emit_mov(OPC_MOV_RM | 8'h2, {MOD_DISP16, 3'd5, 3'd7}, 16'hFFFF, 16'h0);
		emit_mov(OPC_MOV_RM | 8'h1, {MOD_REG, 3'd3, 3'd6}, 16'h0, 16'h0);
		emit_mov(OPC_MOV_RM, {MOD_NONE, 3'd4, 3'd0}, 16'h0, 16'h0);
		emit_mov(OPC_MOV_IMM_RM | 8'h1, {MOD_NONE, 3'd0, RM_DIRECT}, 16'h1234, 16'hFFFF);
		emit_mov(OPC_MOV_IMM_RM, {MOD_DISP16, 3'd7, 3'd2}, 16'h8001, 16'h0080);
		emit_mov(OPC_MOV_IMM_RM | 8'h1, {MOD_REG, 3'd5, 3'd7}, 16'h0, 16'h0000);
		emit_mov(OPC_MOV_IMM_RM, {MOD_DISP8, 3'd0, 3'd3}, 16'h0080, 16'h00FF);
		emit_mov(OPC_MOV_IMM_REG | 8'hF, 8'h0, 16'h0, 16'hFFFF);
		emit_mov(OPC_MOV_IMM_REG, 8'h0, 16'h0, 16'h0000);
		emit_mov(OPC_MOV_IMM_REG | 8'h7, 8'h0, 16'h0, 16'h00FF);
		emit_mov(OPC_MOV_IMM_REG | 8'h8, 8'h0, 16'h0, 16'h0001);
		emit_mov(OPC_MOV_MEM_ACC, 8'h0, 16'h0, 16'hFFFF);
		emit_mov(OPC_MOV_MEM_ACC | 8'h1, 8'h0, 16'h0, 16'h0000);
		emit_mov(OPC_MOV_ACC_MEM, 8'h0, 16'h0, 16'h8001);
		emit_mov(OPC_MOV_ACC_MEM | 8'h1, 8'h0, 16'h0, 16'h7FFE);
		drain();

		for (int p = 0; p < 4; p++) begin
			send_calm = (p == 1 || p == 2);
			recv_calm = (p == 2);
			if (p == 1) hold_results_req = 1'b1;
			target = bytes_sent + 400;
			while (bytes_sent < target) random_instr();
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Result side: random stalls, plus one long hold-off while input keeps coming.
	initial begin
		int n;
		bit held;
		held = 1'b0;
		out_stall = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_results_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
			end else begin
				n = recv_calm ? 0 : $urandom_range(0, 19);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
				end
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		dec_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.form = form;
			got.direction = direction;
			got.wide = wide;
			got.mode = mode;
			got.reg_code = reg_code;
			got.rm_code = rm_code;
			got.direct_address = direct_address;
			got.displacement = displacement;
			got.data_value = data_value;
			got.length = length;
			sb.check_record(got);
		end
	end

endmodule
